FILE: rtl/pkvu_pkg.sv
// Shared types and constants of the periodic knot vector update block.
// Used by pkvu_ctrl, pkvu_dp and periodic_knot_vector_update; no dependencies.
`default_nettype none

package pkvu_pkg;

    // Field widths of the streams and the configuration registers
    localparam int DEG_W  = 5;
    localparam int LAST_W = 6;
    localparam int PER_W  = 31;
    localparam int IDX_W  = 6;
    localparam int MULT_W = 6;
    localparam int VAL_W  = 32;
    localparam int CIDX_W = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DEGREE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LAST   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PERIOD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DEG_W-1:0]  DEG_RESET  = 5'd3;
    localparam logic [LAST_W-1:0] LAST_RESET = 6'd63;
    localparam logic [PER_W-1:0]  PER_RESET  = 31'd65536;

    // Datapath operations issued by the controller
    typedef enum logic [5:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_REJECT,
        OP_MAP,
        OP_A_RD,
        OP_A_HIT,
        OP_A_VAL,
        OP_SCAN_DN,
        OP_M_INC,
        OP_A_CALL,
        OP_A_STEP,
        OP_ITER_CLR,
        OP_B_RD,
        OP_B_HIT,
        OP_SCAN_UP,
        OP_B_RDV,
        OP_B_CALL,
        OP_B_STEP,
        OP_C_CALL,
        OP_G0_INIT,
        OP_G_WR_UP,
        OP_G1_INIT,
        OP_G1_NEXT,
        OP_G2_INIT,
        OP_G2_NEXT,
        OP_G_WR_DN,
        OP_D_INIT,
        OP_D_WR,
        OP_E_INIT,
        OP_E_RD1,
        OP_E_RD0,
        OP_E_WR,
        OP_F_INIT,
        OP_F_RD1,
        OP_F_RD0,
        OP_F_WR,
        OP_H_JUMP,
        OP_H_RD,
        OP_H_DEC,
        OP_U_JUMP,
        OP_U_RD,
        OP_U_INC,
        OP_FIN,
        OP_PUSH
    } t_op;

    // Datapath status returned to the controller
    typedef struct packed {
        logic mode;
        logic bad;
        logic a_go;
        logic a_lt;
        logic a_scan;
        logic eq;
        logic b_go;
        logic b_gt;
        logic b_scan;
        logic g_cnt;
        logic g1_out;
        logic g1_in;
        logic g2_out;
        logic g2_in;
        logic d_diff;
        logic d_go;
        logic e_go;
        logic f_go;
        logic h_go;
        logic h_jump;
        logic h_gt;
        logic u_go;
        logic u_jump;
        logic u_le;
    } t_flags;

endpackage

`default_nettype wire

FILE: rtl/pkvu_ctrl.sv
// Sequencer of the knot vector update: one-hot state machine that issues
// datapath operations and owns the stream handshakes. Depends on pkvu_pkg.
`default_nettype none

module pkvu_ctrl import pkvu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    input  wire t_flags i_flags,
    output t_op         o_op
);

    typedef enum logic [38:0] {
        S_IDLE   = 39'b1 << 0,
        S_DISP   = 39'b1 << 1,
        S_CHK    = 39'b1 << 2,
        S_A_CHK  = 39'b1 << 3,
        S_A_CMP  = 39'b1 << 4,
        S_A_VAL  = 39'b1 << 5,
        S_A_SCAN = 39'b1 << 6,
        S_A_EQ   = 39'b1 << 7,
        S_A_CALL = 39'b1 << 8,
        S_A_STEP = 39'b1 << 9,
        S_B_CHK  = 39'b1 << 10,
        S_B_CMP  = 39'b1 << 11,
        S_B_SCAN = 39'b1 << 12,
        S_B_EQ   = 39'b1 << 13,
        S_B_RDV  = 39'b1 << 14,
        S_B_CALL = 39'b1 << 15,
        S_B_STEP = 39'b1 << 16,
        S_C_CALL = 39'b1 << 17,
        S_D_CHK  = 39'b1 << 18,
        S_D_WR   = 39'b1 << 19,
        S_E_INIT = 39'b1 << 20,
        S_E_CHK  = 39'b1 << 21,
        S_E_RD   = 39'b1 << 22,
        S_E_WR   = 39'b1 << 23,
        S_F_CHK  = 39'b1 << 24,
        S_F_RD   = 39'b1 << 25,
        S_F_WR   = 39'b1 << 26,
        S_H_CHK  = 39'b1 << 27,
        S_H_CMP  = 39'b1 << 28,
        S_U_CHK  = 39'b1 << 29,
        S_U_CMP  = 39'b1 << 30,
        S_RESULT = 39'b1 << 31,
        S_DONE   = 39'b1 << 32,
        S_G0     = 39'b1 << 33,
        S_G0_WR  = 39'b1 << 34,
        S_G1     = 39'b1 << 35,
        S_G1_WR  = 39'b1 << 36,
        S_G2     = 39'b1 << 37,
        S_G2_WR  = 39'b1 << 38
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, group-write return point and operation select
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_flags.mode) begin
                    n_state = S_CHK;
                end else begin
                    o_op    = OP_LOAD;
                    n_state = S_DONE;
                end
            end
            S_CHK: begin
                if (i_flags.bad) begin
                    o_op    = OP_REJECT;
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_MAP;
                    n_state = S_A_CHK;
                end
            end
            // Move lower groups while the new value sits below them
            S_A_CHK: begin
                if (i_flags.a_go) begin
                    o_op    = OP_A_RD;
                    n_state = S_A_CMP;
                end else begin
                    o_op    = OP_ITER_CLR;
                    n_state = S_B_CHK;
                end
            end
            S_A_CMP: begin
                if (i_flags.a_lt) begin
                    o_op    = OP_A_HIT;
                    n_state = S_A_VAL;
                end else begin
                    o_op    = OP_ITER_CLR;
                    n_state = S_B_CHK;
                end
            end
            S_A_VAL: begin
                o_op    = OP_A_VAL;
                n_state = S_A_SCAN;
            end
            S_A_SCAN: begin
                if (i_flags.a_scan) begin
                    o_op    = OP_SCAN_DN;
                    n_state = S_A_EQ;
                end else begin
                    n_state = S_A_CALL;
                end
            end
            S_A_EQ: begin
                if (i_flags.eq) begin
                    o_op    = OP_M_INC;
                    n_state = S_A_SCAN;
                end else begin
                    n_state = S_A_CALL;
                end
            end
            S_A_CALL: begin
                o_op    = OP_A_CALL;
                n_ret   = S_A_STEP;
                n_state = S_G0;
            end
            S_A_STEP: begin
                o_op    = OP_A_STEP;
                n_state = S_A_CHK;
            end
            // Move upper groups while the new value sits above them
            S_B_CHK: begin
                if (i_flags.b_go) begin
                    o_op    = OP_B_RD;
                    n_state = S_B_CMP;
                end else begin
                    n_state = S_C_CALL;
                end
            end
            S_B_CMP: begin
                if (i_flags.b_gt) begin
                    o_op    = OP_B_HIT;
                    n_state = S_B_SCAN;
                end else begin
                    n_state = S_C_CALL;
                end
            end
            S_B_SCAN: begin
                if (i_flags.b_scan) begin
                    o_op    = OP_SCAN_UP;
                    n_state = S_B_EQ;
                end else begin
                    n_state = S_B_RDV;
                end
            end
            S_B_EQ: begin
                if (i_flags.eq) begin
                    o_op    = OP_M_INC;
                    n_state = S_B_SCAN;
                end else begin
                    n_state = S_B_RDV;
                end
            end
            S_B_RDV: begin
                o_op    = OP_B_RDV;
                n_state = S_B_CALL;
            end
            S_B_CALL: begin
                o_op    = OP_B_CALL;
                n_ret   = S_B_STEP;
                n_state = S_G0;
            end
            S_B_STEP: begin
                o_op    = OP_B_STEP;
                n_state = S_B_CHK;
            end
            // Place the new group itself
            S_C_CALL: begin
                o_op    = OP_C_CALL;
                n_ret   = S_D_CHK;
                n_state = S_G0;
            end
            S_D_CHK: begin
                if (i_flags.d_diff) begin
                    o_op    = OP_D_INIT;
                    n_state = S_D_WR;
                end else begin
                    n_state = S_E_INIT;
                end
            end
            S_D_WR: begin
                if (i_flags.d_go) begin
                    o_op = OP_D_WR;
                end else begin
                    n_state = S_E_INIT;
                end
            end
            // Clamp downwards to a monotone vector
            S_E_INIT: begin
                o_op    = OP_E_INIT;
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (i_flags.e_go) begin
                    o_op    = OP_E_RD1;
                    n_state = S_E_RD;
                end else begin
                    o_op    = OP_F_INIT;
                    n_state = S_F_CHK;
                end
            end
            S_E_RD: begin
                o_op    = OP_E_RD0;
                n_state = S_E_WR;
            end
            S_E_WR: begin
                o_op    = OP_E_WR;
                n_state = S_E_CHK;
            end
            // Clamp upwards
            S_F_CHK: begin
                if (i_flags.f_go) begin
                    o_op    = OP_F_RD1;
                    n_state = S_F_RD;
                end else begin
                    n_state = S_H_CHK;
                end
            end
            S_F_RD: begin
                o_op    = OP_F_RD0;
                n_state = S_F_WR;
            end
            S_F_WR: begin
                o_op    = OP_F_WR;
                n_state = S_F_CHK;
            end
            // Search the last knot at most the value
            S_H_CHK: begin
                if (!i_flags.h_go) begin
                    n_state = S_U_CHK;
                end else if (i_flags.h_jump) begin
                    o_op = OP_H_JUMP;
                end else begin
                    o_op    = OP_H_RD;
                    n_state = S_H_CMP;
                end
            end
            S_H_CMP: begin
                if (i_flags.h_gt) begin
                    o_op    = OP_H_DEC;
                    n_state = S_H_CHK;
                end else begin
                    n_state = S_U_CHK;
                end
            end
            S_U_CHK: begin
                if (!i_flags.u_go) begin
                    n_state = S_RESULT;
                end else if (i_flags.u_jump) begin
                    o_op = OP_U_JUMP;
                end else begin
                    o_op    = OP_U_RD;
                    n_state = S_U_CMP;
                end
            end
            S_U_CMP: begin
                if (i_flags.u_le) begin
                    o_op    = OP_U_INC;
                    n_state = S_U_CHK;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                o_op    = OP_FIN;
                n_state = S_DONE;
            end
            // Hand the result over once the output register is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op        = OP_PUSH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            // Group write: the group, then upper copies, then lower copies
            S_G0: begin
                o_op    = OP_G0_INIT;
                n_state = S_G0_WR;
            end
            S_G0_WR: begin
                if (i_flags.g_cnt) begin
                    o_op = OP_G_WR_UP;
                end else begin
                    o_op    = OP_G1_INIT;
                    n_state = S_G1;
                end
            end
            S_G1: begin
                if (i_flags.g1_out) begin
                    n_state = S_G1_WR;
                end else begin
                    o_op    = OP_G2_INIT;
                    n_state = S_G2;
                end
            end
            S_G1_WR: begin
                if (i_flags.g1_in) begin
                    o_op = OP_G_WR_UP;
                end else begin
                    o_op    = OP_G1_NEXT;
                    n_state = S_G1;
                end
            end
            S_G2: begin
                if (i_flags.g2_out) begin
                    n_state = S_G2_WR;
                end else begin
                    n_state = r_ret;
                end
            end
            S_G2_WR: begin
                if (i_flags.g2_in) begin
                    o_op = OP_G_WR_DN;
                end else begin
                    o_op    = OP_G2_NEXT;
                    n_state = S_G2;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pkvu_dp.sv
// Datapath of the knot vector update: configuration registers, knot memory,
// index and value registers, output register. Depends on pkvu_pkg.
`default_nettype none

module pkvu_dp import pkvu_pkg::*; #(
    parameter int MAX_KNOTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [PER_W-1:0]   i_cfg_data,
    input  wire logic               i_mode,
    input  wire logic [IDX_W-1:0]   i_knot_index,
    input  wire logic [MULT_W-1:0]  i_multiplicity,
    input  wire logic [VAL_W-1:0]   i_knot_value,
    input  wire t_op                i_op,
    output t_flags                  o_flags,
    output logic                    o_status,
    output logic [IDX_W-1:0]        o_new_index
);

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int XW = 2 * AW + 4;
    localparam int VW = 2 * AW + 40;
    localparam int CW = AW + 3;
    localparam logic [CW-1:0]        LOOP_CAP = CW'(4 * MAX_KNOTS);
    localparam logic signed [XW-1:0] ZERO_X   = XW'(0);
    localparam logic signed [XW-1:0] ONE_X    = XW'(1);
    localparam logic signed [XW-1:0] MAXK_X   = XW'(MAX_KNOTS);
    localparam logic signed [VW-1:0] QMAX     = VW'(64'sd2147483647);
    localparam logic signed [VW-1:0] QMIN     = -QMAX - VW'(1);

    // Configuration
    logic [DEG_W-1:0]  r_deg;
    logic [LAST_W-1:0] r_last;
    logic [PER_W-1:0]  r_per;

    // Item fields
    logic              r_mode, n_mode;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [MULT_W-1:0] r_mult, n_mult;
    logic [VAL_W-1:0]  r_t, n_t;

    // Working registers
    logic signed [XW-1:0] r_kn, n_kn, r_knum, n_knum, r_m, n_m, r_i, n_i;
    logic signed [XW-1:0] r_p, n_p, r_c, n_c, r_base, n_base, r_gk, n_gk, r_gm, n_gm;
    logic signed [VW-1:0] r_tt, n_tt, r_gv, n_gv, r_acc, n_acc, r_a, n_a;
    logic [CW-1:0]        r_iter, n_iter;
    logic                 r_res_st, n_res_st;
    logic [IDX_W-1:0]     r_res_idx, n_res_idx;
    logic                 r_out_st, n_out_st;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;

    // Memory and its ports
    logic [VAL_W-1:0]     mem [MAX_KNOTS];
    logic [VAL_W-1:0]     r_qraw;
    logic                 r_qok;
    logic signed [XW-1:0] rd_addr, w_addr;
    logic signed [VW-1:0] w_val;
    logic                 w_en, w_load, we;
    logic [AW-1:0]        wa;
    logic [VAL_W-1:0]     wd;

    // Widened views
    logic signed [XW-1:0] last_x, deg_x, k_x, mult_x, idx_x, kt;
    logic signed [VW-1:0] t_v, per_v, q_v;

    function automatic logic [VAL_W-1:0] sat32(input logic signed [VW-1:0] v);
        logic [VAL_W-1:0] res;
        if (v > QMAX) begin
            res = 32'h7FFF_FFFF;
        end else if (v < QMIN) begin
            res = 32'h8000_0000;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

    assign last_x = $signed({{(XW-LAST_W){1'b0}}, r_last});
    assign deg_x  = $signed({{(XW-DEG_W){1'b0}}, r_deg});
    assign mult_x = $signed({{(XW-MULT_W){1'b0}}, r_mult});
    assign idx_x  = $signed({{(XW-IDX_W){1'b0}}, r_idx});
    assign k_x    = last_x - (deg_x <<< 1);
    assign t_v    = $signed({{(VW-VAL_W){r_t[VAL_W-1]}}, r_t});
    assign per_v  = $signed({{(VW-PER_W){1'b0}}, r_per});
    assign q_v    = r_qok ? $signed({{(VW-VAL_W){r_qraw[VAL_W-1]}}, r_qraw}) : '0;

    // Status towards the controller
    always_comb begin
        o_flags.mode   = r_mode;
        o_flags.bad    = (r_deg == '0) || (last_x >= MAXK_X) ||
                         (last_x <= deg_x * XW'(3)) || (r_mult == '0) ||
                         (mult_x > k_x) || (idx_x >= last_x);
        o_flags.a_go   = (r_iter < LOOP_CAP) && (r_kn > ONE_X);
        o_flags.a_lt   = r_tt < q_v;
        o_flags.a_scan = (r_kn - ONE_X - r_m) > ZERO_X;
        o_flags.eq     = q_v == r_a;
        o_flags.b_go   = (r_iter < LOOP_CAP) && (r_kn < last_x - ONE_X);
        o_flags.b_gt   = r_tt > q_v;
        o_flags.b_scan = (r_kn + ONE_X + r_m) < last_x;
        o_flags.g_cnt  = r_c > ZERO_X;
        o_flags.g1_out = (r_base - r_gm) <= last_x;
        o_flags.g1_in  = (r_c > ZERO_X) && (r_p <= last_x);
        o_flags.g2_out = r_base >= ZERO_X;
        o_flags.g2_in  = (r_c > ZERO_X) && (r_p >= ZERO_X);
        o_flags.d_diff = r_kn != r_knum;
        o_flags.d_go   = (r_i < mult_x) && ((r_knum - r_i) >= ZERO_X);
        o_flags.e_go   = r_i >= ZERO_X;
        o_flags.f_go   = r_i <= last_x;
        o_flags.h_go   = r_knum > mult_x;
        o_flags.h_jump = (r_knum > last_x) && r_t[VAL_W-1];
        o_flags.h_gt   = q_v > t_v;
        o_flags.u_go   = r_knum < (last_x - ONE_X);
        o_flags.u_jump = (r_knum < -ONE_X) && !r_t[VAL_W-1];
        o_flags.u_le   = q_v <= t_v;
    end

    // Operation decode
    always_comb begin
        n_mode    = r_mode;
        n_idx     = r_idx;
        n_mult    = r_mult;
        n_t       = r_t;
        n_kn      = r_kn;
        n_knum    = r_knum;
        n_m       = r_m;
        n_i       = r_i;
        n_p       = r_p;
        n_c       = r_c;
        n_base    = r_base;
        n_gk      = r_gk;
        n_gm      = r_gm;
        n_tt      = r_tt;
        n_gv      = r_gv;
        n_acc     = r_acc;
        n_a       = r_a;
        n_iter    = r_iter;
        n_res_st  = r_res_st;
        n_res_idx = r_res_idx;
        n_out_st  = r_out_st;
        n_out_idx = r_out_idx;
        rd_addr   = '0;
        w_en      = 1'b0;
        w_load    = 1'b0;
        w_addr    = '0;
        w_val     = '0;
        kt        = '0;
        case (i_op)
            OP_ACCEPT: begin
                n_mode = i_mode;
                n_idx  = i_knot_index;
                n_mult = i_multiplicity;
                n_t    = i_knot_value;
            end
            OP_LOAD: begin
                if (idx_x < MAXK_X) begin
                    w_en      = 1'b1;
                    w_load    = 1'b1;
                    w_addr    = idx_x;
                    w_val     = t_v;
                    n_res_st  = 1'b0;
                    n_res_idx = r_idx;
                end else begin
                    n_res_st  = 1'b1;
                    n_res_idx = '0;
                end
            end
            OP_REJECT: begin
                n_res_st  = 1'b1;
                n_res_idx = '0;
            end
            // Map the index into the central range
            OP_MAP: begin
                n_knum = idx_x;
                n_iter = '0;
                if (idx_x - mult_x + ONE_X < deg_x) begin
                    n_kn = idx_x + k_x;
                    n_tt = t_v + per_v;
                end else if (idx_x > last_x - deg_x) begin
                    n_kn = idx_x - k_x;
                    n_tt = t_v - per_v;
                end else begin
                    n_kn = idx_x;
                    n_tt = t_v;
                end
            end
            OP_A_RD:    rd_addr = r_kn - mult_x;
            OP_A_HIT: begin
                rd_addr = r_kn - ONE_X;
                n_m     = ONE_X;
            end
            OP_A_VAL:   n_a = q_v;
            OP_SCAN_DN: rd_addr = r_kn - ONE_X - r_m;
            OP_M_INC:   n_m = r_m + ONE_X;
            OP_A_CALL: begin
                n_gk = r_kn;
                n_gm = r_m;
                n_gv = r_a;
            end
            OP_A_STEP: begin
                kt     = r_kn - r_m;
                n_knum = r_knum - r_m;
                n_iter = r_iter + CW'(1);
                if (kt <= r_m) begin
                    n_kn = kt + k_x;
                    n_tt = r_tt + per_v;
                end else begin
                    n_kn = kt;
                end
            end
            OP_ITER_CLR: n_iter = '0;
            OP_B_RD:     rd_addr = r_kn + ONE_X;
            OP_B_HIT: begin
                n_a = q_v;
                n_m = ONE_X;
            end
            OP_SCAN_UP:  rd_addr = r_kn + ONE_X + r_m;
            OP_B_RDV:    rd_addr = r_kn + r_m;
            OP_B_CALL: begin
                n_gk = r_kn;
                n_gm = r_m;
                n_gv = q_v;
            end
            OP_B_STEP: begin
                kt     = r_kn + r_m;
                n_knum = r_knum + r_m;
                n_iter = r_iter + CW'(1);
                if (kt >= last_x) begin
                    n_kn = kt - k_x;
                    n_tt = r_tt - per_v;
                end else begin
                    n_kn = kt;
                end
            end
            OP_C_CALL: begin
                n_gk = r_kn;
                n_gm = mult_x;
                n_gv = r_tt;
            end
            // Group and periodic copies
            OP_G0_INIT: begin
                n_acc = r_gv;
                n_p   = r_gk - r_gm + ONE_X;
                n_c   = r_gm;
            end
            OP_G_WR_UP: begin
                w_en   = 1'b1;
                w_addr = r_p;
                w_val  = r_acc;
                n_p    = r_p + ONE_X;
                n_c    = r_c - ONE_X;
            end
            OP_G1_INIT: begin
                n_base = r_gk + k_x;
                n_acc  = r_gv + per_v;
                n_p    = r_gk + k_x - r_gm + ONE_X;
                n_c    = r_gm;
            end
            OP_G1_NEXT: begin
                n_base = r_base + k_x;
                n_acc  = r_acc + per_v;
                n_p    = r_base + k_x - r_gm + ONE_X;
                n_c    = r_gm;
            end
            OP_G2_INIT: begin
                n_base = r_gk - k_x;
                n_acc  = r_gv - per_v;
                n_p    = r_gk - k_x;
                n_c    = r_gm;
            end
            OP_G2_NEXT: begin
                n_base = r_base - k_x;
                n_acc  = r_acc - per_v;
                n_p    = r_base - k_x;
                n_c    = r_gm;
            end
            OP_G_WR_DN: begin
                w_en   = 1'b1;
                w_addr = r_p;
                w_val  = r_acc;
                n_p    = r_p - ONE_X;
                n_c    = r_c - ONE_X;
            end
            // Rewrite the original run when the group moved
            OP_D_INIT: n_i = '0;
            OP_D_WR: begin
                w_en   = 1'b1;
                w_addr = r_knum - r_i;
                w_val  = t_v;
                n_i    = r_i + ONE_X;
            end
            // Monotone clamp, downwards then upwards
            OP_E_INIT: n_i = (r_knum - ONE_X < last_x) ? r_knum - ONE_X : last_x;
            OP_E_RD1:  rd_addr = r_i + ONE_X;
            OP_E_RD0: begin
                n_a     = q_v;
                rd_addr = r_i;
            end
            OP_E_WR: begin
                w_en   = q_v > r_a;
                w_addr = r_i;
                w_val  = r_a;
                n_i    = r_i - ONE_X;
            end
            OP_F_INIT: n_i = (r_knum + ONE_X > ONE_X) ? r_knum + ONE_X : ONE_X;
            OP_F_RD1:  rd_addr = r_i - ONE_X;
            OP_F_RD0: begin
                n_a     = q_v;
                rd_addr = r_i;
            end
            OP_F_WR: begin
                w_en   = q_v < r_a;
                w_addr = r_i;
                w_val  = r_a;
                n_i    = r_i + ONE_X;
            end
            // Final index search; indexes outside the vector read as zero
            OP_H_JUMP: n_knum = last_x;
            OP_H_RD:   rd_addr = r_knum;
            OP_H_DEC:  n_knum = r_knum - ONE_X;
            OP_U_JUMP: n_knum = -ONE_X;
            OP_U_RD:   rd_addr = r_knum + ONE_X;
            OP_U_INC:  n_knum = r_knum + ONE_X;
            OP_FIN: begin
                n_res_st = 1'b0;
                if (r_knum < ZERO_X) begin
                    n_res_idx = '0;
                end else if (r_knum > last_x) begin
                    n_res_idx = r_last;
                end else begin
                    n_res_idx = r_knum[IDX_W-1:0];
                end
            end
            OP_PUSH: begin
                n_out_st  = r_res_st;
                n_out_idx = r_res_idx;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // Drop writes outside the vector, except for a direct load
    assign we = w_en && (w_load || ((w_addr >= ZERO_X) && (w_addr <= last_x)));
    assign wa = w_addr[AW-1:0];
    assign wd = sat32(w_val);

    // Knot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_qraw <= mem[rd_addr[AW-1:0]];
        r_qok  <= (rd_addr >= ZERO_X) && (rd_addr <= last_x) && (rd_addr < MAXK_X);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg  <= DEG_RESET;
            r_last <= LAST_RESET;
            r_per  <= PER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEGREE: r_deg  <= i_cfg_data[DEG_W-1:0];
                CFG_LAST:   r_last <= i_cfg_data[LAST_W-1:0];
                CFG_PERIOD: r_per  <= i_cfg_data;
                default:    r_deg  <= r_deg;
            endcase
        end
    end

    // Working and output registers
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_idx     <= n_idx;
        r_mult    <= n_mult;
        r_t       <= n_t;
        r_kn      <= n_kn;
        r_knum    <= n_knum;
        r_m       <= n_m;
        r_i       <= n_i;
        r_p       <= n_p;
        r_c       <= n_c;
        r_base    <= n_base;
        r_gk      <= n_gk;
        r_gm      <= n_gm;
        r_tt      <= n_tt;
        r_gv      <= n_gv;
        r_acc     <= n_acc;
        r_a       <= n_a;
        r_iter    <= n_iter;
        r_res_st  <= n_res_st;
        r_res_idx <= n_res_idx;
        r_out_st  <= n_out_st;
        r_out_idx <= n_out_idx;
    end

    assign o_status    = r_out_st;
    assign o_new_index = r_out_idx;

endmodule

`default_nettype wire

FILE: rtl/periodic_knot_vector_update.sv
// Periodic knot vector update. Usage and timing:
// Input stream s_axis: one transaction per command. tuser carries the mode
// (0 loads one knot, 1 sets a knot group with multiplicity); tdata carries
// knot_index, multiplicity and the Q16.16 knot value.
// Output stream m_axis: one transaction per command, tuser the status
// (1 rejected), tdata the resulting index.
// Configuration: i_cfg_we writes register i_cfg_index (0 degree, 1 last
// index, 2 period) in the same cycle; write only while no command is in flight.
// Flow: a load goes from acceptance through the dispatch state to the output
// register, a rejected set also through the check state. An accepted set runs
// one command at a time through the sequencer and the knot memory (one write,
// one registered read port): monotone passes go entry by entry, every group
// rewrite writes one entry per cycle, and each scanned neighbour takes its own
// read. A new command is taken only while the sequencer is idle.
// Stalls: a finished result sits in the output register; the next command is
// accepted and processed meanwhile, and its result waits until that register
// drains. Reset clears the sequencer and restores the configuration registers;
// knot contents stay undefined until loaded. Depends on pkvu_pkg, pkvu_ctrl
// and pkvu_dp.
`default_nettype none

module periodic_knot_vector_update import pkvu_pkg::*; #(
    parameter int MAX_KNOTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [PER_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] knot_index, [11:6] multiplicity, [43:12] knot_value, [47:44] zero
    input  wire logic [47:0]       s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [5:0] new_index, [7:6] zero
    output logic [7:0]             m_axis_tdata,
    // [0] status
    output logic [0:0]             m_axis_tuser
);

    t_op              op;
    t_flags           flags;
    logic             status;
    logic [IDX_W-1:0] new_index;

    pkvu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_flags     (flags),
        .o_op        (op)
    );

    pkvu_dp #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (s_axis_tuser[0]),
        .i_knot_index   (s_axis_tdata[5:0]),
        .i_multiplicity (s_axis_tdata[11:6]),
        .i_knot_value   (s_axis_tdata[43:12]),
        .i_op           (op),
        .o_flags        (flags),
        .o_status       (status),
        .o_new_index    (new_index)
    );

    assign m_axis_tdata = {2'b00, new_index};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for periodic_knot_vector_update.
// Drives the command stream and configuration port, predicts each result with a
// behavioural knot vector model; depends on pkvu_pkg and the block's RTL.
`default_nettype none

class knot_scoreboard;
    logic signed [31:0] knots [64];
    int unsigned        degree;
    int unsigned        last;
    longint             period;
    logic [0:0]         status_q [$];
    logic [5:0]         index_q [$];
    int                 errors;

    function void init();
        for (int i = 0; i < 64; i++) begin
            knots[i] = 0;
        end
        degree = 3;
        last = 63;
        period = 65536;
        errors = 0;
    endfunction

    function logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function longint rd(int i);
        if (i < 0 || i > int'(last) || i >= 64) return 0;
        return longint'(knots[i]);
    endfunction

    function void wr(int i, longint v);
        if (i < 0 || i > int'(last) || i >= 64) return;
        knots[i] = sat(v);
    endfunction

    // Set group of m knots ending at kn to t, plus every periodic copy
    function void set_group(int k, int l, int kn, int m, longint t);
        for (int i = 1 - m; i <= 0; i++) wr(kn + i, t);
        for (int j = 1; kn + j * k - m <= l; j++)
            for (int i = 1 - m; i <= 0 && kn + j * k + i <= l; i++)
                wr(kn + j * k + i, t + longint'(j) * period);
        for (int j = 1; kn - j * k >= 0; j++)
            for (int i = 0; i < m && kn - j * k - i >= 0; i++)
                wr(kn - j * k - i, t - longint'(j) * period);
    endfunction

    // Note one accepted command and queue its expected result
    function void note_command(bit mode, int idx, int mult, logic signed [31:0] value);
        int d, l, k, kn, num, m, iter;
        longint t, tt;
        d = degree;
        l = last;
        t = longint'(value);
        if (!mode) begin
            knots[idx] = value;
            status_q.push_back(0);
            index_q.push_back(idx[5:0]);
            return;
        end
        k = l - 2 * d;
        if (d == 0 || l >= 64 || l <= 3 * d || mult == 0 || mult > k || idx >= l) begin
            status_q.push_back(1);
            index_q.push_back(0);
            return;
        end
        num = idx;
        if (num - mult + 1 < d) begin
            kn = num + k; tt = t + period;
        end else if (num > l - d) begin
            kn = num - k; tt = t - period;
        end else begin
            kn = num; tt = t;
        end
        for (iter = 0; iter < 256 && kn > 1 && tt < rd(kn - mult); iter++) begin
            m = 1;
            while (kn - 1 - m > 0 && rd(kn - 1 - m) == rd(kn - 1)) m++;
            set_group(k, l, kn, m, rd(kn - 1));
            kn -= m;
            num -= m;
            if (kn <= m) begin
                kn += k; tt += period;
            end
        end
        for (iter = 0; iter < 256 && kn < l - 1 && tt > rd(kn + 1); iter++) begin
            m = 1;
            while (kn + 1 + m < l && rd(kn + 1 + m) == rd(kn + 1)) m++;
            set_group(k, l, kn, m, rd(kn + m));
            kn += m;
            num += m;
            if (kn >= l) begin
                kn -= k; tt -= period;
            end
        end
        set_group(k, l, kn, mult, tt);
        if (kn != num)
            for (int i = 0; i < mult && num - i >= 0; i++) wr(num - i, t);
        for (int i = num - 1; i >= 0; i--)
            if (i <= l && rd(i) > rd(i + 1)) wr(i, rd(i + 1));
        for (int i = (num + 1 > 1 ? num + 1 : 1); i <= l; i++)
            if (rd(i) < rd(i - 1)) wr(i, rd(i - 1));
        while (num > mult && rd(num) > t) num--;
        while (num < l - 1 && rd(num + 1) <= t) num++;
        if (num < 0) num = 0;
        if (num > l) num = l;
        status_q.push_back(0);
        index_q.push_back(num[5:0]);
    endfunction

    // Compare one result transaction against the oldest expectation
    function void check_result(logic [0:0] status, logic [5:0] new_index);
        logic [0:0] exp_status;
        logic [5:0] exp_index;
        if (status_q.size() == 0) begin
            $error("unexpected result status=%0d new_index=%0d", status, new_index);
            errors++;
            return;
        end
        exp_status = status_q.pop_front();
        exp_index = index_q.pop_front();
        if (status !== exp_status) begin
            $error("status: expected %0d actual %0d", exp_status, status);
            errors++;
        end
        if (new_index !== exp_index) begin
            $error("new_index: expected %0d actual %0d", exp_index, new_index);
            errors++;
        end
    endfunction

    function int pending();
        return status_q.size();
    endfunction
endclass

module tb;
    import pkvu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [CIDX_W-1:0] i_cfg_index = CFG_DEGREE;
    logic [PER_W-1:0]  i_cfg_data = '0;
    logic              s_axis_tvalid = 0;
    logic              s_axis_tready;
    // [5:0] knot_index, [11:6] multiplicity, [43:12] knot_value, [47:44] zero
    logic [47:0]       s_axis_tdata = '0;
    // [0] mode
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 0;
    // [5:0] new_index, [7:6] zero
    logic [7:0]        m_axis_tdata;
    // [0] status
    logic [0:0]        m_axis_tuser;

    knot_scoreboard board;
    int             idle_pct = 28;

    periodic_knot_vector_update i_dut (.*);

    initial forever #6 i_clk = ~i_clk;

    // Hard limit on the run
    initial begin
        #400ms;
        $display("periodic_knot_vector_update regression: fail");
        $finish;
    end

    // Result side: random stall, check each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata[5:0]);
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Write one register, then wait with the write enable low before the next write
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [PER_W-1:0] value);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_DEGREE) board.degree = value[4:0];
        else if (idx == CFG_LAST) board.last = value[5:0];
        else board.period = value;
        @(posedge i_clk);
    endtask

    // Present one command; tvalid stays up after acceptance until the next
    // command, an idle cycle or a drain takes it over
    task automatic send_command(bit mode, int idx, int mult, logic [31:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {4'b0, value, mult[5:0], idx[5:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_command(mode, idx, mult, value);
    endtask

    // Wait for every expected result, then let the sequencer settle
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        while (board.pending() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("periodic_knot_vector_update regression: fail");
            $finish;
        end
        repeat (20) @(posedge i_clk);
    endtask

    // Load an increasing knot vector over 0..last with the given step
    task automatic load_vector(int step);
        for (int i = 0; i <= int'(board.last); i++)
            send_command(0, i, $urandom_range(63), 32'(i * step - 10 * step));
    endtask

    function automatic logic [31:0] near_value();
        int span;
        span = int'(board.last) * 65536;
        return 32'($urandom_range(span + 131072) - 131072);
    endfunction

    initial begin
        int l, d;
        board = new();
        board.init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes of a load, out-of-range arguments
        write_reg(CFG_PERIOD, 31'd65536);
        load_vector(4096);
        send_command(0, 63, 63, 32'h7fffffff);
        send_command(0, 0, 0, 32'h80000000);
        send_command(0, 63, 0, 32'(63 * 4096));
        send_command(0, 0, 1, 32'(-40960));
        send_command(1, 63, 1, 32'h0);
        send_command(1, 10, 0, 32'h0);
        send_command(1, 10, 63, 32'h0);
        send_command(1, 0, 1, 32'h7fffffff);
        send_command(1, 62, 3, 32'h80000000);
        send_command(1, 2, 2, 32'(20 * 4096));
        send_command(1, 30, 1, 32'(5 * 4096));
        send_command(1, 30, 57, 32'(30 * 4096));
        drain();
        write_reg(CFG_DEGREE, 5'd0);
        send_command(1, 5, 1, 32'h100);
        drain();
        write_reg(CFG_DEGREE, 5'd20);
        send_command(1, 5, 1, 32'h100);
        drain();
        write_reg(CFG_DEGREE, 5'd1);
        write_reg(CFG_LAST, 6'd1);
        send_command(1, 0, 1, 32'h100);
        drain();
        write_reg(CFG_LAST, 6'd4);
        write_reg(CFG_PERIOD, 31'h7fffffff);
        send_command(1, 1, 1, 32'h100);
        drain();
        write_reg(CFG_PERIOD, 31'd0);
        load_vector(65536);
        send_command(1, 3, 2, 32'h18000);

        // Random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            idle_pct = (ph == 5) ? 0 : 28;
            d = $urandom_range(1, 6);
            l = $urandom_range(3 * d + 1, 63);
            if (ph == 0) begin d = 1; l = 63; end
            write_reg(CFG_DEGREE, 5'(d));
            write_reg(CFG_LAST, 6'(l));
            write_reg(CFG_PERIOD, (ph == 1) ? 31'h7fffffff :
                      31'((l - 2 * d) * $urandom_range(30000, 70000)));
            load_vector($urandom_range(4096, 65536));
            for (int n = 0; n < 16; n++) begin
                if ($urandom_range(9) == 0)
                    send_command($urandom_range(1), $urandom_range(63),
                                 $urandom_range(63), $urandom());
                else if ($urandom_range(4) == 0)
                    send_command(0, $urandom_range(l), 0, near_value());
                else
                    send_command(1, $urandom_range(l - 1), $urandom_range(1, l - 2 * d),
                                 near_value());
            end
        end
        drain();
        if (board.errors == 0)
            $display("periodic_knot_vector_update regression: pass");
        else
            $display("periodic_knot_vector_update regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
